>>> rtl/core/stable_priority_queue_unit_macros.svh
// ---------------------------------------------------------------------------
// stable priority queue assertion macros
// shared property forms for the checker of the queue unit
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, quiet while reset is held
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication that also covers the reset cycles
`define SPQ_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/core/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// types and stream packing constants of the stable priority queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    // operation carried in the input tuser
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    // input item fields
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned S_PRIO_LSB  = 0;
    localparam int unsigned S_DATA_LSB  = 8;

    // result item fields
    localparam int unsigned M_TDATA_W   = 24;
    localparam int unsigned M_TUSER_W   = 2;
    localparam int unsigned M_DATA_LSB  = 0;
    localparam int unsigned M_PRIO_LSB  = 8;
    localparam int unsigned M_COUNT_LSB = 16;
    localparam int unsigned M_PAD_LSB   = 21;
    localparam int unsigned M_PAD_W     = 3;
    localparam int unsigned U_POP_VALID = 0;
    localparam int unsigned U_DROPPED   = 1;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COUNT_W     = 5;

endpackage

>>> rtl/core/stable_priority_queue_unit.sv
// ---------------------------------------------------------------------------
// stable priority queue unit
// bounded sorted queue of byte items, ties leave in arrival order
// ---------------------------------------------------------------------------
// Every item is either a push (tuser = 0) of a payload byte with a priority,
// or a pop (tuser = 1) of the head entry, which holds the lowest priority
// value; equal priorities leave in the order they arrived. Each item yields
// exactly one result item carrying the entry count after that item. A pop on
// an empty queue returns pop_valid = 0 with zero data and priority; a push to
// a full queue is dropped and flagged with push_dropped. The entries live in
// a row of CAPACITY cells, each comparing its own priority with the incoming
// one in parallel and loading from itself or a neighbour, so each item is
// handled by the single cell update and then the result register: one item
// per cycle while the result side takes results. The input side stays ready
// while the result register is empty or being taken.
`timescale 1ns / 1ps

module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY       = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [7:0] item_priority, [15:8] data_byte
    input  logic                 i_s_axis_tuser,   // [0] op
    // result item stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // [7:0] pop_data, [15:8] pop_priority,
                                                   // [20:16] entry_count, [23:21] zero
    output logic [M_TUSER_W-1:0] o_m_axis_tuser    // [0] pop_valid, [1] push_dropped
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CNT_XW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int PRI_XW = (PRIORITY_WIDTH > BYTE_W) ? PRIORITY_WIDTH : BYTE_W;

    // queue cells, slot 0 is the head
    logic [PRIORITY_WIDTH-1:0] r_prio [CAPACITY];
    logic [BYTE_W-1:0]         r_data [CAPACITY];
    logic [CAPACITY-1:0]       r_valid;
    logic [CAPACITY-1:0]       n_valid;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;

    // result register
    logic                      r_out_valid;
    logic                      r_pop_valid;
    logic [BYTE_W-1:0]         r_pop_data;
    logic [BYTE_W-1:0]         r_pop_prio;
    logic                      r_dropped;
    logic [COUNT_W-1:0]        r_out_count;

    logic                      accept;
    t_op                       in_op;
    logic [PRIORITY_WIDTH-1:0] in_prio;
    logic [BYTE_W-1:0]         in_data;
    logic                      q_full;
    logic                      q_empty;
    logic                      do_push;
    logic                      do_pop;
    logic [CAPACITY-1:0]       later;      // cell sits behind the new item
    logic [PRI_XW-1:0]         head_prio_x;
    logic [CNT_XW-1:0]         count_x;

    // result register frees up in the same cycle it is taken
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign in_op   = t_op'(i_s_axis_tuser);
    // only the low priority bits are kept (zero extended when wider)
    assign in_prio = PRIORITY_WIDTH'(i_s_axis_tdata[S_PRIO_LSB +: BYTE_W]);
    assign in_data = i_s_axis_tdata[S_DATA_LSB +: BYTE_W];

    // valid cells always form a prefix of the row
    assign q_full  = r_valid[CAPACITY-1];
    assign q_empty = !r_valid[0];
    assign do_push = accept && (in_op == OP_PUSH) && !q_full;
    assign do_pop  = accept && (in_op == OP_POP) && !q_empty;

    // a cell lies behind the new item when empty or strictly greater,
    // so equal priorities stay ahead and the order is stable
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            later[i] = !r_valid[i] || (r_prio[i] > in_prio);
        end
    end

    // per-cell update: insert, shift back, shift forward or hold
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [PRIORITY_WIDTH-1:0] prev_prio;
        logic [BYTE_W-1:0]         prev_data;
        logic                      prev_later;
        logic [PRIORITY_WIDTH-1:0] next_prio;
        logic [BYTE_W-1:0]         next_data;

        if (g == 0) begin : g_first
            assign prev_prio  = in_prio;
            assign prev_data  = in_data;
            assign prev_later = 1'b0;
        end else begin : g_mid
            assign prev_prio  = r_prio[g-1];
            assign prev_data  = r_data[g-1];
            assign prev_later = later[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            // tail cell becomes invalid on a pop, its contents do not matter
            assign next_prio = r_prio[g];
            assign next_data = r_data[g];
        end else begin : g_body
            assign next_prio = r_prio[g+1];
            assign next_data = r_data[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (do_push && later[g]) begin
                if (prev_later) begin
                    r_prio[g] <= prev_prio;
                    r_data[g] <= prev_data;
                end else begin
                    // first cell behind the new item takes it
                    r_prio[g] <= in_prio;
                    r_data[g] <= in_data;
                end
            end else if (do_pop) begin
                r_prio[g] <= next_prio;
                r_data[g] <= next_data;
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        if (do_push) begin
            n_valid = {r_valid[CAPACITY-2:0], 1'b1};
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_valid = {1'b0, r_valid[CAPACITY-1:1]};
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    // head priority reported as its low byte
    assign head_prio_x = PRI_XW'(r_prio[0]);
    // count reported masked to the field width
    assign count_x     = CNT_XW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pop_valid <= do_pop;
            r_pop_data  <= do_pop ? r_data[0] : '0;
            r_pop_prio  <= do_pop ? head_prio_x[BYTE_W-1:0] : '0;
            r_dropped   <= (in_op == OP_PUSH) && q_full;
            r_out_count <= count_x[COUNT_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out_count, r_pop_prio, r_pop_data};
    assign o_m_axis_tuser  = {r_dropped, r_pop_valid};

endmodule

>>> rtl/core/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker
// port-level assertions for the stable priority queue unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stable_priority_queue_unit_macros.svh"

module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    logic                          out_pop_valid;
    logic                          out_dropped;
    logic [COUNT_W-1:0]            out_count;
    logic [2*BYTE_W-1:0]           out_entry;
    logic                          out_stalled;
    logic [M_TUSER_W+M_TDATA_W-1:0] out_word;

    assign out_pop_valid = o_m_axis_tuser[U_POP_VALID];
    assign out_dropped   = o_m_axis_tuser[U_DROPPED];
    assign out_count     = o_m_axis_tdata[M_COUNT_LSB +: COUNT_W];
    assign out_entry     = o_m_axis_tdata[M_DATA_LSB +: 2*BYTE_W];
    assign out_stalled   = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word      = {o_m_axis_tuser, o_m_axis_tdata};

    // no result is shown in the cycle after reset
    `SPQ_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid)

    // a stalled result holds its contents
    `SPQ_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, out_stalled, o_m_axis_tvalid && $stable(out_word))

    // a dropped push only happens with the queue at capacity
    `SPQ_ASSERT_IMP(a_drop_full, i_clk, i_rst_n, o_m_axis_tvalid && out_dropped, !out_pop_valid && (out_count == COUNT_W'(CAPACITY)))

    // results without a removed entry carry zero data and priority
    `SPQ_ASSERT_IMP(a_no_pop_zero, i_clk, i_rst_n, o_m_axis_tvalid && !out_pop_valid, out_entry == '0)

endmodule

bind stable_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
